@@ sv/lcg_stream_cipher_checksum_top_macros.svh @@
// Assertion macros for the LCG stream cipher checksum block.
// Included by the top level; needs nothing else.
`ifndef LCG_STREAM_CIPHER_CHECKSUM_TOP_MACROS_SVH
`define LCG_STREAM_CIPHER_CHECKSUM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LCGSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcgsc: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LCGSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcgsc: next-cycle check failed");

`endif

@@ sv/lcgsc_pkg.sv @@
// Types, constants and constant tables of the LCG stream cipher checksum block.
// No dependencies; used by the channel interfaces and the top level.
package lcgsc_pkg;

   // Field widths
   localparam int KeyW    = 20;
   localparam int SumW    = 23;
   localparam int ByteW   = 8;
   localparam int SeedW   = 15;
   localparam int ReqW    = 2;
   localparam int KeyLinW = 22;   // unreduced key sum, below 4 * key modulus
   localparam int SumLinW = 25;   // unreduced checksum, below 3 * checksum modulus

   // Arithmetic constants
   localparam longint KeyModVal = 894871;
   localparam longint SumModVal = 6506347;
   localparam logic [KeyW-1:0]    KeyMod    = KeyW'(KeyModVal);
   localparam logic [11:0]        KeyMult   = 12'd2399;
   localparam logic [KeyW-1:0]    KeyOffset = 20'd667818;
   localparam logic [SumW-1:0]    SumMod    = SumW'(SumModVal);
   localparam logic [SumW-1:0]    SumInit   = 23'd1232531;

   // Reduction thresholds
   localparam logic [KeyLinW-1:0] KeyMod1L = KeyLinW'(KeyModVal);
   localparam logic [KeyLinW-1:0] KeyMod2L = KeyLinW'(2 * KeyModVal);
   localparam logic [KeyLinW-1:0] KeyMod3L = KeyLinW'(3 * KeyModVal);
   localparam logic [SumLinW-1:0] SumMod1L = SumLinW'(SumModVal);
   localparam logic [SumLinW-1:0] SumMod2L = SumLinW'(2 * SumModVal);

   // Key split: bits 19:13 and 12:6 go through tables, bits 5:0 multiply directly
   localparam int KeyHiLsb     = 13;
   localparam int KeyMidLsb    = 6;
   localparam int KeyTabDepth  = 128;
   localparam int SumTabDepth  = 256;
   localparam int SumLoW       = 15;

   typedef logic [KeyW-1:0] key_tab_type [KeyTabDepth];
   typedef logic [SumW-1:0] sum_tab_type [SumTabDepth];

   // Entry i = (i << shift) * multiplier mod key modulus
   function automatic key_tab_type build_key_tab(input int shift);
      key_tab_type tab;
      longint      term;
      for (int i = 0; i < KeyTabDepth; i++) begin
         term   = (longint'(i) << shift) * longint'(KeyMult);
         tab[i] = KeyW'(term % KeyModVal);
      end
      return tab;
   endfunction

   // Entry i = (i << 23) mod checksum modulus: upper checksum bits after the byte shift
   function automatic sum_tab_type build_sum_tab();
      sum_tab_type tab;
      longint      term;
      for (int i = 0; i < SumTabDepth; i++) begin
         term   = longint'(i) << SumW;
         tab[i] = SumW'(term % SumModVal);
      end
      return tab;
   endfunction

   localparam key_tab_type KeyTabHi  = build_key_tab(KeyHiLsb);
   localparam key_tab_type KeyTabMid = build_key_tab(KeyMidLsb);
   localparam sum_tab_type SumTabHi  = build_sum_tab();

   // Request codes
   typedef enum logic [ReqW-1:0] {
      ReqStart = 2'd0,
      ReqData  = 2'd1,
      ReqEnd   = 2'd2
   } req_kind_type;

   // Register file
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam int CsrIdxW  = 1;
   localparam logic [CsrIdxW-1:0] CsrIdxDecrypt = 1'b0;

   typedef struct packed {
      logic [ReqW-1:0]  req_type;
      logic [SeedW-1:0] seed_value;
      logic [ByteW-1:0] data_in;
      logic [SumW-1:0]  stored_sum;
   } req_item_type;

   typedef struct packed {
      logic [ByteW-1:0] data_out;
      logic [SumW-1:0]  running_sum;
      logic             sum_match;
      logic             frame_done;
   } rsp_item_type;

endpackage

@@ sv/lcgsc_ifs.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on lcgsc_pkg for field widths.
interface lcgsc_req_if
   import lcgsc_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [ReqW-1:0]  req_type;
   logic [SeedW-1:0] seed_value;
   logic [ByteW-1:0] data_in;
   logic [SumW-1:0]  stored_sum;

   modport source (output valid, req_type, seed_value, data_in, stored_sum, input ready);
   modport sink   (input valid, req_type, seed_value, data_in, stored_sum, output ready);
endinterface

interface lcgsc_rsp_if
   import lcgsc_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] data_out;
   logic [SumW-1:0]  running_sum;
   logic             sum_match;
   logic             frame_done;

   modport source (output valid, data_out, running_sum, sum_match, frame_done, input ready);
   modport sink   (input valid, data_out, running_sum, sum_match, frame_done, output ready);
endinterface

@@ sv/lcg_stream_cipher_checksum_top.sv @@
// Top level of the LCG keystream byte cipher with plaintext checksum.
// Depends on lcgsc_pkg, lcgsc_ifs.sv and lcg_stream_cipher_checksum_top_macros.svh.
//
//   channel   direction  handshake           carries
//   req_chan  in         valid/ready         request code, seed, byte, stored checksum
//   rsp_chan  out        valid/ready         ciphered byte, checksum, match, frame done
//   csr_*     in/out     APB, pready tied 1  decrypt_mode at address 0
//
// One request per cycle sustained while rsp_chan takes results; the request register
// loads at the accepting edge and the result register when that request advances
// out of it. The key and checksum updates are table lookups, a small multiply for
// the key, one add and a parallel compare/subtract, all between the two registers.
// A stall on rsp_chan holds the result register and backs up into the request
// register; req_chan.ready drops only when both are full.
// Reset (synchronous, high) empties both stages, clears the key, loads the
// checksum seed value and selects encrypt mode.
`include "lcg_stream_cipher_checksum_top_macros.svh"

module lcg_stream_cipher_checksum_top
   import lcgsc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   lcgsc_req_if.sink           req_chan,
   lcgsc_rsp_if.source         rsp_chan,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   logic                decrypt_mode_ff;
   logic                decrypt_mode_in;
   logic [CsrIdxW-1:0]  csr_idx;
   logic                csr_wr;

   logic                req_valid_ff;
   logic                req_valid_in;
   req_item_type        req_item_ff;
   req_item_type        req_item_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_item_type        rsp_item_ff;
   rsp_item_type        rsp_item_in;
   logic                advance;

   logic [KeyW-1:0]     key_ff;
   logic [KeyW-1:0]     key_in;
   logic [SumW-1:0]     sum_ff;
   logic [SumW-1:0]     sum_in;

   logic [KeyLinW-1:0]  key_lin;
   logic [KeyW-1:0]     key_next;
   logic [ByteW-1:0]    cipher_byte;
   logic [ByteW-1:0]    plain_byte;
   logic [SumLinW-1:0]  sum_lin;
   logic [SumW-1:0]     sum_next;
   req_kind_type        req_kind;

   // Register port: one register, pready always high
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CsrAddrW-1:CsrAddrW-CsrIdxW];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      decrypt_mode_in = decrypt_mode_ff;
      if (csr_wr && (csr_idx == CsrIdxDecrypt)) begin
         decrypt_mode_in = csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_idx == CsrIdxDecrypt) ?
                       {{(CsrDataW-1){1'b0}}, decrypt_mode_ff} : '0;

   // Two-stage flow: request register feeds result register
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_item_in  = req_item_ff;
      if (req_chan.valid && req_chan.ready) begin
         req_valid_in           = 1'b1;
         req_item_in.req_type   = req_chan.req_type;
         req_item_in.seed_value = req_chan.seed_value;
         req_item_in.data_in    = req_chan.data_in;
         req_item_in.stored_sum = req_chan.stored_sum;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   // Key step: (key * 2399 + 667818) mod 894871, split over two tables
   assign key_lin = KeyLinW'(KeyTabHi[key_ff[KeyW-1:KeyHiLsb]])
                  + KeyLinW'(KeyTabMid[key_ff[KeyHiLsb-1:KeyMidLsb]])
                  + KeyLinW'(key_ff[KeyMidLsb-1:0]) * KeyLinW'(KeyMult)
                  + KeyLinW'(KeyOffset);

   always_comb begin
      if (key_lin >= KeyMod3L) begin
         key_next = KeyW'(key_lin - KeyMod3L);
      end else if (key_lin >= KeyMod2L) begin
         key_next = KeyW'(key_lin - KeyMod2L);
      end else if (key_lin >= KeyMod1L) begin
         key_next = KeyW'(key_lin - KeyMod1L);
      end else begin
         key_next = KeyW'(key_lin);
      end
   end

   // Keystream byte is bits 17..10 of the new key
   assign cipher_byte = req_item_ff.data_in ^ key_next[17:10];
   assign plain_byte  = decrypt_mode_ff ? cipher_byte : req_item_ff.data_in;

   // Checksum step: (sum * 256 + plain) mod 6506347
   assign sum_lin = SumLinW'(SumTabHi[sum_ff[SumW-1:SumLoW]])
                  + SumLinW'({sum_ff[SumLoW-1:0], {ByteW{1'b0}}})
                  + SumLinW'(plain_byte);

   always_comb begin
      if (sum_lin >= SumMod2L) begin
         sum_next = SumW'(sum_lin - SumMod2L);
      end else if (sum_lin >= SumMod1L) begin
         sum_next = SumW'(sum_lin - SumMod1L);
      end else begin
         sum_next = SumW'(sum_lin);
      end
   end

   // Per-request state update and result
   assign req_kind = req_kind_type'(req_item_ff.req_type);

   always_comb begin
      key_in                  = key_ff;
      sum_in                  = sum_ff;
      rsp_item_in.data_out    = '0;
      rsp_item_in.running_sum = sum_ff;
      rsp_item_in.sum_match   = 1'b0;
      rsp_item_in.frame_done  = 1'b0;
      case (req_kind)
         ReqStart: begin
            key_in                  = KeyW'(req_item_ff.seed_value);
            sum_in                  = SumInit;
            rsp_item_in.running_sum = SumInit;
         end
         ReqData: begin
            key_in                  = key_next;
            sum_in                  = sum_next;
            rsp_item_in.data_out    = cipher_byte;
            rsp_item_in.running_sum = sum_next;
         end
         ReqEnd: begin
            rsp_item_in.sum_match  = (req_item_ff.stored_sum == sum_ff);
            rsp_item_in.frame_done = 1'b1;
         end
         default: begin
            // unused code: result reports the checksum, state untouched
         end
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.data_out    = rsp_item_ff.data_out;
   assign rsp_chan.running_sum = rsp_item_ff.running_sum;
   assign rsp_chan.sum_match   = rsp_item_ff.sum_match;
   assign rsp_chan.frame_done  = rsp_item_ff.frame_done;

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_mode_ff <= 1'b0;
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         key_ff          <= '0;
         sum_ff          <= SumInit;
      end else begin
         decrypt_mode_ff <= decrypt_mode_in;
         req_valid_ff    <= req_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (advance) begin
            key_ff <= key_in;
            sum_ff <= sum_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // Checks
   `LCGSC_ASSERT_NOW(a_sum_in_range, clock, reset, rsp_valid_ff, rsp_item_ff.running_sum < SumMod)
   `LCGSC_ASSERT_NEXT(a_key_in_range, clock, reset, advance && (req_kind == ReqData), key_ff < KeyMod)
   `LCGSC_ASSERT_NOW(a_match_on_end, clock, reset, rsp_valid_ff && rsp_item_ff.sum_match, rsp_item_ff.frame_done)
   `LCGSC_ASSERT_NEXT(a_stalled_req_kept, clock, reset, req_valid_ff && !advance, req_valid_ff)

endmodule

@@ bench/lcgsc_tb_pkg.sv @@
// Bench-side request codes, register addresses and the cipher/checksum tracker.
// Depends on lcgsc_pkg for field widths and item structs.
package lcgsc_tb_pkg;
   import lcgsc_pkg::*;

   // Request code the block answers with the checksum, without touching state
   localparam logic [ReqW-1:0] ReqIgnored = 2'd3;

   // Register map: decrypt_mode is register 0, byte address 0
   localparam logic [CsrAddrW-1:0] CsrAddrDecrypt = 3'd0;

   // Keystream generator and checksum constants
   localparam longint unsigned KeyStepMult = 2399;
   localparam longint unsigned KeyStepAdd  = 667818;
   localparam longint unsigned KeyModulus  = 894871;
   localparam longint unsigned SumModulus  = 6506347;
   localparam logic [SumW-1:0] SumSeed     = 23'd1232531;

   class cipher_frame_tracker;
      logic [KeyW-1:0] key_reg;
      logic [SumW-1:0] sum_reg;
      bit              decrypt;
      rsp_item_type    pending_outputs[$];
      int              fail_count;

      function new();
         key_reg    = '0;
         sum_reg    = SumSeed;
         decrypt    = 1'b0;
         fail_count = 0;
      endfunction

      // Step the key/checksum for one accepted request, queue the result it owes
      function void note_request(req_item_type cmd);
         rsp_item_type     out;
         longint unsigned  acc;
         logic [ByteW-1:0] plain;
         out = '0;
         case (cmd.req_type)
            ReqStart: begin
               key_reg = KeyW'(cmd.seed_value);
               sum_reg = SumSeed;
            end
            ReqData: begin
               acc          = longint'(key_reg) * KeyStepMult + KeyStepAdd;
               key_reg      = KeyW'(acc % KeyModulus);
               out.data_out = cmd.data_in ^ key_reg[17:10];
               plain        = decrypt ? out.data_out : cmd.data_in;
               acc          = (longint'(sum_reg) << 8) + plain;
               sum_reg      = SumW'(acc % SumModulus);
            end
            ReqEnd: begin
               // compared as given, so out-of-range trailers never match
               out.sum_match  = (cmd.stored_sum == sum_reg);
               out.frame_done = 1'b1;
            end
            default: ;
         endcase
         out.running_sum = sum_reg;
         pending_outputs.push_back(out);
      endfunction

      function void check_field(string fname, logic [31:0] want, logic [31:0] seen,
                                time stamp);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", stamp, fname, want, seen);
            fail_count++;
         end
      endfunction

      // Compare one delivered result against the oldest outstanding one
      function void check_result(rsp_item_type got, time stamp);
         rsp_item_type want;
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", stamp, got);
            fail_count++;
         end else begin
            want = pending_outputs.pop_front();
            check_field("data_out", want.data_out, got.data_out, stamp);
            check_field("running_sum", want.running_sum, got.running_sum, stamp);
            check_field("sum_match", want.sum_match, got.sum_match, stamp);
            check_field("frame_done", want.frame_done, got.frame_done, stamp);
         end
      endfunction

      function int outstanding();
         return pending_outputs.size();
      endfunction
   endclass

endpackage

@@ bench/tb_lcg_stream_cipher_checksum_top.sv @@
// Testbench for the LCG stream cipher checksum top: directed and framed random requests,
// random gaps and backpressure, results checked against a tracked key/checksum.
// Depends on lcgsc_pkg, lcgsc_ifs.sv, lcgsc_tb_pkg and the top-level RTL.
module tb_lcg_stream_cipher_checksum_top;
   import lcgsc_pkg::*;
   import lcgsc_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 2000;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   lcgsc_req_if req_chan ();
   lcgsc_rsp_if rsp_chan ();

   cipher_frame_tracker tracker = new();

   bit           gaps_on   = 1'b1;
   bit           stalls_on = 1'b1;
   int           items_sent;
   int           ready_left;
   int           quiet_cycles;
   rsp_item_type rsp_seen;

   lcg_stream_cipher_checksum_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result side: random stall bursts, free-running when stalls are off
   always @(negedge clock) begin
      if (!stalls_on) begin
         rsp_chan.ready <= 1'b1;
      end else if (ready_left > 0) begin
         ready_left--;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_chan.ready <= 1'b0;
         ready_left = $urandom_range(0, 12);
      end else begin
         rsp_chan.ready <= 1'b1;
         ready_left = $urandom_range(0, 24);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_seen.data_out    = rsp_chan.data_out;
         rsp_seen.running_sum = rsp_chan.running_sum;
         rsp_seen.sum_match   = rsp_chan.sum_match;
         rsp_seen.frame_done  = rsp_chan.frame_done;
         tracker.check_result(rsp_seen, $time);
      end
   end

   // Watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if (reset || csr_psel || (req_chan.valid && req_chan.ready)
          || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Request of the given kind with every other field random; callers overwrite what matters
   function automatic req_item_type make_req(logic [ReqW-1:0] kind);
      req_item_type cmd;
      cmd.req_type   = kind;
      cmd.seed_value = SeedW'($urandom);
      cmd.data_in    = ByteW'($urandom);
      cmd.stored_sum = SumW'($urandom);
      return cmd;
   endfunction

   // Trailer value: mostly the right checksum, else near misses, random values and out-of-range
   function automatic logic [SumW-1:0] pick_trailer();
      case ($urandom_range(0, 9))
         7:       return tracker.sum_reg ^ (SumW'(1) << $urandom_range(0, SumW - 1));
         8:       return SumW'($urandom);
         9:       return SumW'($urandom_range(SumModulus, (1 << SumW) - 1));
         default: return tracker.sum_reg;
      endcase
   endfunction

   // Drive one request from a falling edge, hold until accepted, end on a falling edge
   task automatic send_req(input req_item_type cmd, input bit allow_gap);
      int gap;
      gap = (gaps_on && allow_gap && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= cmd.req_type;
      req_chan.seed_value <= cmd.seed_value;
      req_chan.data_in    <= cmd.data_in;
      req_chan.stored_sum <= cmd.stored_sum;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      tracker.note_request(cmd);
      if (cmd.req_type != ReqIgnored) items_sent++;
      @(negedge clock);
   endtask

   // Register write then read-back; only called with the block idle
   task automatic set_decrypt(input bit mode);
      logic [CsrDataW-1:0] word;
      word    = $urandom;
      word[0] = mode;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CsrAddrDecrypt;
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.decrypt = mode;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CsrDataW'(mode)) begin
         $display("%0t: decrypt_mode read mismatch, expected %0h, actual %0h",
                  $time, CsrDataW'(mode), csr_prdata);
         tracker.fail_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Stop offering requests, then wait until every result is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
   endtask

   // Frames of start / data / end with random content, plus some loose requests
   task automatic run_traffic(input int budget, input int calm_after);
      req_item_type cmd;
      int           first;
      int           nbytes;
      int           pick;
      bit           frame_gaps;
      first = items_sent;
      while (items_sent - first < budget) begin
         if (items_sent - first >= calm_after) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         frame_gaps = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 99) < 85) begin
            cmd = make_req(ReqStart);
            pick = $urandom_range(0, 7);
            if (pick == 0) cmd.seed_value = '0;
            else if (pick == 1) cmd.seed_value = '1;
            send_req(cmd, frame_gaps);
            nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                 : $urandom_range(0, 12);
            for (int b = 0; b < nbytes; b++) begin
               pick = $urandom_range(0, 29);
               if (pick == 0) begin
                  // end in mid-frame; the frame carries on after it
                  cmd = make_req(ReqEnd);
                  cmd.stored_sum = pick_trailer();
               end else if (pick == 1) begin
                  cmd = make_req(ReqIgnored);
               end else begin
                  cmd = make_req(ReqData);
                  if (pick == 2) cmd.data_in = '0;
                  else if (pick == 3) cmd.data_in = '1;
               end
               send_req(cmd, frame_gaps);
            end
            cmd = make_req(ReqEnd);
            cmd.stored_sum = pick_trailer();
            send_req(cmd, frame_gaps);
         end else begin
            cmd = make_req(ReqW'($urandom_range(0, 3)));
            send_req(cmd, frame_gaps);
         end
      end
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.req_type   = '0;
      req_chan.seed_value = '0;
      req_chan.data_in    = '0;
      req_chan.stored_sum = '0;
      rsp_chan.ready      = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      items_sent          = 0;
      ready_left          = 0;
      quiet_cycles        = 0;
      reset               = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: data before any start, ignored code, end mid-frame, trailer extremes
      set_decrypt(1'b0);
      begin
         req_item_type cmd;
         cmd = make_req(ReqData);    cmd.data_in = 8'h00;       send_req(cmd, 1'b1);
         cmd = make_req(ReqData);    cmd.data_in = 8'hff;       send_req(cmd, 1'b1);
         cmd = make_req(ReqEnd);     cmd.stored_sum = tracker.sum_reg; send_req(cmd, 1'b1);
         cmd = make_req(ReqIgnored);                            send_req(cmd, 1'b1);
         cmd = make_req(ReqStart);   cmd.seed_value = '0;       send_req(cmd, 1'b1);
         cmd = make_req(ReqData);    cmd.data_in = 8'ha5;       send_req(cmd, 1'b1);
         cmd = make_req(ReqEnd);     cmd.stored_sum = '0;       send_req(cmd, 1'b1);
         cmd = make_req(ReqData);    cmd.data_in = 8'h3c;       send_req(cmd, 1'b1);
         cmd = make_req(ReqEnd);     cmd.stored_sum = SumW'(SumModulus); send_req(cmd, 1'b1);
         cmd = make_req(ReqStart);   cmd.seed_value = '1;       send_req(cmd, 1'b1);
         cmd = make_req(ReqData);    cmd.data_in = 8'hff;       send_req(cmd, 1'b1);
         cmd = make_req(ReqData);    cmd.data_in = 8'h00;       send_req(cmd, 1'b1);
         cmd = make_req(ReqEnd);     cmd.stored_sum = '1;       send_req(cmd, 1'b1);
         cmd = make_req(ReqStart);   cmd.seed_value = 15'd12345; send_req(cmd, 1'b1);
         cmd = make_req(ReqEnd);     cmd.stored_sum = SumSeed;  send_req(cmd, 1'b1);
         cmd = make_req(ReqEnd);     cmd.stored_sum = SumW'(SumModulus - 1); send_req(cmd, 1'b1);
         cmd = make_req(ReqIgnored);                            send_req(cmd, 1'b1);
      end
      drain();

      // Random phases, alternating mode; the tail of the last one runs without gaps or stalls
      set_decrypt(1'b1);
      run_traffic(350, 350);
      drain();
      set_decrypt(1'b0);
      run_traffic(350, 350);
      drain();
      set_decrypt(1'b1);
      run_traffic(330, 180);
      drain();
      repeat (10) @(negedge clock);

      if (tracker.fail_count == 0 && tracker.outstanding() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/lcgsc_pkg.sv
sv/lcgsc_ifs.sv
sv/lcg_stream_cipher_checksum_top.sv
bench/lcgsc_tb_pkg.sv
bench/tb_lcg_stream_cipher_checksum_top.sv
